>>> hw/rtl/pwbc_pkg.sv
package pwbc_pkg;

    localparam int TIMER_MODULO = 50000;

    localparam int FUNC_W    = 2;
    localparam int CAPTURE_W = 16;
    localparam int WIDTH_W   = 24;
    localparam int LIMIT_W   = 24;
    localparam int TIMEOUT_W = 8;
    localparam int OVF_W     = 8;
    localparam int COUNT_W   = 16;
    localparam int CLASS_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Timer ticks added to the running overflow product per overflow.
    localparam logic [WIDTH_W-1:0] MODULO_TICKS = WIDTH_W'(TIMER_MODULO);
    localparam logic [OVF_W-1:0]   OVF_MAX      = {OVF_W{1'b1}};

    localparam logic [LIMIT_W-1:0]   B_LOW_RESET   = LIMIT_W'(250000);
    localparam logic [LIMIT_W-1:0]   B_HIGH_RESET  = LIMIT_W'(310000);
    localparam logic [LIMIT_W-1:0]   A_HIGH_RESET  = LIMIT_W'(350000);
    localparam logic [LIMIT_W-1:0]   C_HIGH_RESET  = LIMIT_W'(420000);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(15);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_OVERFLOW = 2'd0,
        FUNC_EDGE     = 2'd1,
        FUNC_TOGGLE   = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_A    = 2'd0,
        CLASS_B    = 2'd1,
        CLASS_C    = 2'd2,
        CLASS_NONE = 2'd3
    } class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B_LOW   = 3'd0,
        REG_B_HIGH  = 3'd1,
        REG_A_HIGH  = 3'd2,
        REG_C_HIGH  = 3'd3,
        REG_TIMEOUT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]   b_low;
        logic [LIMIT_W-1:0]   b_high;
        logic [LIMIT_W-1:0]   a_high;
        logic [LIMIT_W-1:0]   c_high;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic               running;
        logic               alarm;
        logic               class_valid;
        logic [CLASS_W-1:0] bottle_class;
        logic [WIDTH_W-1:0] pulse_width;
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        logic [COUNT_W-1:0] count_c;
        logic [COUNT_W-1:0] count_none;
    } result_t;

endpackage

>>> hw/rtl/pwbc_cfg.sv
module pwbc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pwbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwbc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output pwbc_pkg::cfg_t                    cfg
);

    pwbc_pkg::cfg_t cfg_reg;
    pwbc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pwbc_pkg::REG_B_LOW:   cfg_next.b_low   = cfg_wdata;
                pwbc_pkg::REG_B_HIGH:  cfg_next.b_high  = cfg_wdata;
                pwbc_pkg::REG_A_HIGH:  cfg_next.a_high  = cfg_wdata;
                pwbc_pkg::REG_C_HIGH:  cfg_next.c_high  = cfg_wdata;
                pwbc_pkg::REG_TIMEOUT: cfg_next.timeout = cfg_wdata[pwbc_pkg::TIMEOUT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b_low   <= pwbc_pkg::B_LOW_RESET;
            cfg_reg.b_high  <= pwbc_pkg::B_HIGH_RESET;
            cfg_reg.a_high  <= pwbc_pkg::A_HIGH_RESET;
            cfg_reg.c_high  <= pwbc_pkg::C_HIGH_RESET;
            cfg_reg.timeout <= pwbc_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/pwbc_core.sv
module pwbc_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [pwbc_pkg::FUNC_W-1:0]       func,
    input  logic [pwbc_pkg::CAPTURE_W-1:0]    capture_value,
    input  pwbc_pkg::cfg_t                    cfg,
    output pwbc_pkg::result_t                 res
);

    logic                               run_reg, run_next;
    logic                               phase_reg, phase_next;
    logic                               alarm_reg, alarm_next;
    logic [pwbc_pkg::OVF_W-1:0]         ovf_cnt_reg, ovf_cnt_next;
    logic [pwbc_pkg::WIDTH_W-1:0]       ovf_ticks_reg, ovf_ticks_next;
    logic [pwbc_pkg::CAPTURE_W-1:0]     first_reg, first_next;
    logic [pwbc_pkg::COUNT_W-1:0]       cnt_a_reg, cnt_a_next;
    logic [pwbc_pkg::COUNT_W-1:0]       cnt_b_reg, cnt_b_next;
    logic [pwbc_pkg::COUNT_W-1:0]       cnt_c_reg, cnt_c_next;
    logic [pwbc_pkg::COUNT_W-1:0]       cnt_none_reg, cnt_none_next;

    logic                               ovf_sat;
    logic [pwbc_pkg::OVF_W-1:0]         ovf_cnt_inc;
    logic [pwbc_pkg::WIDTH_W-1:0]       ovf_ticks_inc;
    logic [pwbc_pkg::WIDTH_W-1:0]       width_calc;
    pwbc_pkg::class_t                   width_class;
    logic                               done;

    // The overflow product is kept up to date tick by tick, so no multiplier
    // sits in the width path. It saturates together with the count.
    assign ovf_sat       = (ovf_cnt_reg == pwbc_pkg::OVF_MAX);
    assign ovf_cnt_inc   = ovf_sat ? ovf_cnt_reg : ovf_cnt_reg + 1'b1;
    assign ovf_ticks_inc = ovf_sat ? ovf_ticks_reg : ovf_ticks_reg + pwbc_pkg::MODULO_TICKS;

    // Width wraps at 24 bits, so a capture below the first one with no overflow between gives a large value.
    assign width_calc = ovf_ticks_reg
                      + {{(pwbc_pkg::WIDTH_W-pwbc_pkg::CAPTURE_W){1'b0}}, capture_value}
                      - {{(pwbc_pkg::WIDTH_W-pwbc_pkg::CAPTURE_W){1'b0}}, first_reg};

    always_comb
    begin
        if (width_calc > cfg.b_high && width_calc <= cfg.a_high)
            width_class = pwbc_pkg::CLASS_A;
        else if (width_calc >= cfg.b_low && width_calc <= cfg.b_high)
            width_class = pwbc_pkg::CLASS_B;
        else if (width_calc > cfg.a_high && width_calc <= cfg.c_high)
            width_class = pwbc_pkg::CLASS_C;
        else
            width_class = pwbc_pkg::CLASS_NONE;
    end

    always_comb
    begin
        run_next       = run_reg;
        phase_next     = phase_reg;
        alarm_next     = alarm_reg;
        ovf_cnt_next   = ovf_cnt_reg;
        ovf_ticks_next = ovf_ticks_reg;
        first_next     = first_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        cnt_c_next     = cnt_c_reg;
        cnt_none_next  = cnt_none_reg;
        done           = 1'b0;
        if (step)
        begin
            case (pwbc_pkg::func_t'(func))
                pwbc_pkg::FUNC_OVERFLOW:
                begin
                    ovf_cnt_next   = ovf_cnt_inc;
                    ovf_ticks_next = ovf_ticks_inc;
                    if (run_reg)
                    begin
                        if (ovf_cnt_inc >= cfg.timeout)
                            run_next = 1'b0;
                        if (ovf_cnt_inc == pwbc_pkg::OVF_W'(1))
                            alarm_next = 1'b0;
                    end
                end
                pwbc_pkg::FUNC_EDGE:
                begin
                    if (run_reg)
                    begin
                        ovf_cnt_next   = '0;
                        ovf_ticks_next = '0;
                        phase_next     = !phase_reg;
                        if (!phase_reg)
                        begin
                            first_next = capture_value;
                        end
                        else
                        begin
                            done = 1'b1;
                            case (width_class)
                                pwbc_pkg::CLASS_A: cnt_a_next = cnt_a_reg + 1'b1;
                                pwbc_pkg::CLASS_B: cnt_b_next = cnt_b_reg + 1'b1;
                                pwbc_pkg::CLASS_C: cnt_c_next = cnt_c_reg + 1'b1;
                                default:
                                begin
                                    cnt_none_next = cnt_none_reg + 1'b1;
                                    alarm_next    = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                pwbc_pkg::FUNC_TOGGLE:
                begin
                    run_next       = !run_reg;
                    ovf_cnt_next   = '0;
                    ovf_ticks_next = '0;
                end
                default:
                begin
                    run_next = run_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            alarm_reg     <= 1'b0;
            ovf_cnt_reg   <= '0;
            ovf_ticks_reg <= '0;
            first_reg     <= '0;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            cnt_c_reg     <= '0;
            cnt_none_reg  <= '0;
        end
        else
        begin
            run_reg       <= run_next;
            phase_reg     <= phase_next;
            alarm_reg     <= alarm_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            ovf_ticks_reg <= ovf_ticks_next;
            first_reg     <= first_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            cnt_c_reg     <= cnt_c_next;
            cnt_none_reg  <= cnt_none_next;
        end
    end

    always_comb
    begin
        res.running      = run_next;
        res.alarm        = alarm_next;
        res.class_valid  = done;
        res.bottle_class = done ? width_class : pwbc_pkg::CLASS_W'(0);
        res.pulse_width  = done ? width_calc : '0;
        res.count_a      = cnt_a_next;
        res.count_b      = cnt_b_next;
        res.count_c      = cnt_c_next;
        res.count_none   = cnt_none_next;
    end

endmodule

>>> hw/rtl/pulse_width_bin_classifier_unit.sv
// Pulse width bin classifier. Each request carries one event (overflow tick,
// capture edge or start/stop toggle) and yields exactly one result with the
// running and alarm status, the bin counters and, on the closing edge of a pair,
// the measured width and its bin. The block takes one request per clock cycle
// unless the result register is held by a stalled consumer. A request waits in
// the input register while the update logic computes the result that is written
// into the result register when the request leaves the input register.
// The event state is updated as each request leaves the input register, so
// back-to-back requests see each other's effects. When the result register is
// held by a stalled consumer the input register still takes one more request.
// Configuration writes take effect on the next cycle and must only be made
// while no request is in flight.
module pulse_width_bin_classifier_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pwbc_pkg::FUNC_W-1:0]       func,
    input  logic [pwbc_pkg::CAPTURE_W-1:0]    capture_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              running,
    output logic                              alarm,
    output logic                              class_valid,
    output logic [pwbc_pkg::CLASS_W-1:0]      bottle_class,
    output logic [pwbc_pkg::WIDTH_W-1:0]      pulse_width,
    output logic [pwbc_pkg::COUNT_W-1:0]      count_a,
    output logic [pwbc_pkg::COUNT_W-1:0]      count_b,
    output logic [pwbc_pkg::COUNT_W-1:0]      count_c,
    output logic [pwbc_pkg::COUNT_W-1:0]      count_none,
    input  logic                              cfg_we,
    input  logic [pwbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic                              in_valid_reg;
    logic [pwbc_pkg::FUNC_W-1:0]       func_reg;
    logic [pwbc_pkg::CAPTURE_W-1:0]    capture_reg;
    logic                              out_valid_reg;
    pwbc_pkg::result_t                 out_reg;
    pwbc_pkg::result_t                 res;
    pwbc_pkg::cfg_t                    cfg;
    logic                              advance;
    logic                              step;

    // The result register can take a new result when it is empty or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    pwbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pwbc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .func          (func_reg),
        .capture_value (capture_reg),
        .cfg           (cfg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg    <= func;
            capture_reg <= capture_value;
        end
        if (step)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign running      = out_reg.running;
    assign alarm        = out_reg.alarm;
    assign class_valid  = out_reg.class_valid;
    assign bottle_class = out_reg.bottle_class;
    assign pulse_width  = out_reg.pulse_width;
    assign count_a      = out_reg.count_a;
    assign count_b      = out_reg.count_b;
    assign count_c      = out_reg.count_c;
    assign count_none   = out_reg.count_none;

endmodule

>>> hw/rtl/pwbc_checker.sv
module pwbc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              running,
    input  logic                              alarm,
    input  logic                              class_valid,
    input  logic [pwbc_pkg::CLASS_W-1:0]      bottle_class,
    input  logic [pwbc_pkg::WIDTH_W-1:0]      pulse_width
);

    // A result without a finished pulse carries a zero bin and width.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !class_valid |-> bottle_class == '0 && pulse_width == '0)
        else $error("idle result carries bin or width");

    // A pulse outside every bin must raise the alarm on the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && class_valid && bottle_class == pwbc_pkg::CLASS_NONE |-> alarm)
        else $error("rejected pulse without alarm");

    // A pulse can only finish while measuring is enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && class_valid |-> running)
        else $error("pulse finished while stopped");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind pulse_width_bin_classifier_unit pwbc_checker u_pwbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .running      (running),
    .alarm        (alarm),
    .class_valid  (class_valid),
    .bottle_class (bottle_class),
    .pulse_width  (pulse_width)
);
